/* sv/cdl_pkg.sv */
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared types, constants and calendar tables of the calendar date locator.
// ----------------------------------------------------------------------------
package cdl_pkg;

   localparam int unsigned MAX_DAYS_AFTER_DEF = 4095;
   localparam int unsigned NMON = 12;

   typedef enum logic [1:0] {
      KIND_GREG  = 2'd0,
      KIND_THIRTY = 2'd1,
      KIND_FEST  = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_DAY = 2'd1,
      ST_BAD_DIM = 2'd2,
      ST_SPARE   = 2'd3
   } status_type;

   typedef enum logic {
      CMD_LOCATE = 1'b0,
      CMD_TO_DOY = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_KIND = 1'b0,
      CSR_YEAR = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [0:0] cmd;
      logic [8:0] day_of_year;
      logic [11:0] days_after;
      logic [3:0] month_in;
      logic [5:0] day_in_month_in;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] years_later;
      logic [3:0] month;
      logic [5:0] day_in_month;
      logic [3:0] extra_day;
      logic [1:0] season;
      logic [8:0] day_of_year_out;
   } rsp_type;

   // control that travels along the pipeline beside the day count
   typedef struct packed {
      logic       valid;
      status_type status;
      logic [6:0] r100;   // year mod 100
      logic [1:0] q4;     // (year div 100) mod 4
   } ctl_type;

   typedef logic [8:0] tab9_type [NMON];

   localparam tab9_type START_GREG   = '{9'd1, 9'd32, 9'd60, 9'd91, 9'd121, 9'd152,
                                         9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};
   localparam tab9_type START_THIRTY = '{9'd1, 9'd32, 9'd62, 9'd92, 9'd123, 9'd153,
                                         9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd336};
   localparam tab9_type START_FEST   = '{9'd1, 9'd29, 9'd57, 9'd92, 9'd120, 9'd148,
                                         9'd183, 9'd211, 9'd239, 9'd274, 9'd302, 9'd330};

   typedef logic [5:0] tab6_type [NMON];
   localparam tab6_type LEN_GREG = '{6'd31, 6'd28, 6'd31, 6'd30, 6'd31, 6'd30,
                                     6'd31, 6'd31, 6'd30, 6'd31, 6'd30, 6'd31};
   localparam tab6_type TRAIL_THIRTY = '{6'd1, 6'd0, 6'd0, 6'd1, 6'd0, 6'd0,
                                         6'd1, 6'd0, 6'd1, 6'd0, 6'd1, 6'd0};
   localparam tab6_type TRAIL_FEST = '{6'd0, 6'd0, 6'd7, 6'd0, 6'd0, 6'd7,
                                       6'd0, 6'd0, 6'd7, 6'd0, 6'd0, 6'd7};

   function automatic logic is_leap(kind_type k, logic [6:0] r100, logic [1:0] q4);
      logic by4;
      by4 = (r100[1:0] == 2'd0);
      unique case (k)
         KIND_THIRTY: is_leap = by4;
         KIND_FEST:   is_leap = 1'b0;
         default:     is_leap = by4 && ((r100 != 7'd0) || (q4 == 2'd0));
      endcase
   endfunction

   function automatic logic [8:0] year_len(kind_type k, logic leap);
      unique case (k)
         KIND_FEST: year_len = 9'd364;
         default:   year_len = 9'd365 + {8'd0, leap};
      endcase
   endfunction

   function automatic logic [8:0] month_start(kind_type k, logic leap, logic [3:0] m);
      unique case (k)
         KIND_THIRTY: month_start = START_THIRTY[m] + {8'd0, leap && (m > 4'd6)};
         KIND_FEST:   month_start = START_FEST[m];
         default:     month_start = START_GREG[m] + {8'd0, leap && (m > 4'd1)};
      endcase
   endfunction

   // body days of a month, Gregorian leap day included
   function automatic logic [5:0] month_len(kind_type k, logic leap, logic [3:0] m);
      unique case (k)
         KIND_THIRTY: month_len = 6'd30;
         KIND_FEST:   month_len = 6'd28;
         default:     month_len = LEN_GREG[m] + {5'd0, leap && (m == 4'd1)};
      endcase
   endfunction

   // trailing days after the body, thirty-day leap day included
   function automatic logic [5:0] trail_len(kind_type k, logic leap, logic [3:0] m);
      unique case (k)
         KIND_THIRTY: trail_len = TRAIL_THIRTY[m] + {5'd0, leap && (m == 4'd6)};
         KIND_FEST:   trail_len = TRAIL_FEST[m];
         default:     trail_len = 6'd0;
      endcase
   endfunction

   // first day of season c+1 (boundary c)
   function automatic logic [8:0] season_div(kind_type k, logic leap, logic [1:0] c);
      logic [3:0] mk;
      logic [5:0] cd;
      unique case (k)
         KIND_FEST: begin
            unique case (c)
               2'd0:    begin mk = 4'd1;  cd = 6'd1;  end
               2'd1:    begin mk = 4'd5;  cd = 6'd32; end
               2'd2:    begin mk = 4'd9;  cd = 6'd1;  end
               default: begin mk = 4'd11; cd = 6'd1;  end
            endcase
         end
         KIND_THIRTY: begin
            mk = {c, 2'b0} - {2'b0, c} + 4'd2;
            unique case (c)
               2'd0:    cd = 6'd19;
               2'd1:    cd = 6'd10;
               2'd2:    cd = 6'd21;
               default: cd = 6'd20;
            endcase
         end
         default: begin
            mk = {c, 2'b0} - {2'b0, c} + 4'd2;
            cd = 6'd22;
         end
      endcase
      season_div = month_start(k, leap, mk) + {3'd0, cd} - 9'd1;
   endfunction

endpackage

/* sv/cdl_prep.sv */
// ----------------------------------------------------------------------------
// cdl_prep
// Front stages: split the base year into leap residues, check the command
// and form the day count that the year walk consumes.
// ----------------------------------------------------------------------------
module cdl_prep #(
   parameter int unsigned MAX_DAYS_AFTER = cdl_pkg::MAX_DAYS_AFTER_DEF,
   parameter int unsigned TW = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cdl_pkg::req_type  in_req,
   input  cdl_pkg::kind_type kind,
   input  logic [13:0]       base_year,
   output cdl_pkg::ctl_type  out_ctl,
   output logic [TW-1:0]     out_temp
);

   // stage A: quotient by 100 through reciprocal multiply
   logic             a_valid_ff;
   cdl_pkg::req_type a_req_ff;
   logic [7:0]       a_q_ff;
   logic [26:0]      a_prod;

   assign a_prod = {13'd0, base_year} * 27'd5243;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_req_ff <= in_req;
      a_q_ff   <= a_prod[26:19];
   end

   // stage B: remainder
   logic             b_valid_ff;
   cdl_pkg::req_type b_req_ff;
   logic [6:0]       b_r100_ff;
   logic [1:0]       b_q4_ff;
   logic [14:0]      b_rem;

   assign b_rem = {1'b0, base_year} - ({7'd0, a_q_ff} * 15'd100);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_req_ff  <= a_req_ff;
      b_r100_ff <= b_rem[6:0];
      b_q4_ff   <= a_q_ff[1:0];
   end

   // stage C: validate and form the day count
   logic                 leap;
   logic [8:0]           total;
   logic [5:0]           limit;
   cdl_pkg::status_type  status;
   logic [TW-1:0]        temp;
   cdl_pkg::ctl_type     c_ctl_ff;
   logic [TW-1:0]        c_temp_ff;

   always_comb begin
      leap  = cdl_pkg::is_leap(kind, b_r100_ff, b_q4_ff);
      total = cdl_pkg::year_len(kind, leap);
      limit = '0;
      temp  = '0;
      status = cdl_pkg::ST_OK;
      if (b_req_ff.cmd == cdl_pkg::CMD_LOCATE) begin
         if ((b_req_ff.day_of_year == 9'd0) || (b_req_ff.day_of_year > total) ||
             (32'(b_req_ff.days_after) > 32'(MAX_DAYS_AFTER))) begin
            status = cdl_pkg::ST_BAD_DAY;
         end
         temp = TW'(b_req_ff.day_of_year) + TW'(b_req_ff.days_after);
      end else if (b_req_ff.month_in > 4'd11) begin
         status = cdl_pkg::ST_BAD_DAY;
      end else begin
         limit = cdl_pkg::month_len(kind, leap, b_req_ff.month_in) +
                 cdl_pkg::trail_len(kind, leap, b_req_ff.month_in);
         if ((b_req_ff.day_in_month_in == 6'd0) || (b_req_ff.day_in_month_in > limit)) begin
            status = cdl_pkg::ST_BAD_DIM;
         end
         temp = TW'(cdl_pkg::month_start(kind, leap, b_req_ff.month_in) +
                    {3'd0, b_req_ff.day_in_month_in} - 9'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.valid <= 1'b0;
      end else begin
         c_ctl_ff.valid <= b_valid_ff;
      end
      c_ctl_ff.status <= status;
      c_ctl_ff.r100   <= b_r100_ff;
      c_ctl_ff.q4     <= b_q4_ff;
      c_temp_ff       <= temp;
   end

   assign out_ctl  = c_ctl_ff;
   assign out_temp = c_temp_ff;

endmodule

/* sv/cdl_walk_stage.sv */
// ----------------------------------------------------------------------------
// cdl_walk_stage
// One year of the offset walk: drop one year length when the count runs past
// the year, and advance the year residues.
// ----------------------------------------------------------------------------
module cdl_walk_stage #(
   parameter int unsigned TW = 13,
   parameter int unsigned YW = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  cdl_pkg::kind_type kind,
   input  cdl_pkg::ctl_type  in_ctl,
   input  logic [TW-1:0]     in_temp,
   input  logic [YW-1:0]     in_years,
   output cdl_pkg::ctl_type  out_ctl,
   output logic [TW-1:0]     out_temp,
   output logic [YW-1:0]     out_years
);

   logic [TW-1:0]    len;
   logic             step;
   cdl_pkg::ctl_type ctl_in;
   logic [TW-1:0]    temp_in;
   logic [YW-1:0]    years_in;
   cdl_pkg::ctl_type ctl_ff;
   logic [TW-1:0]    temp_ff;
   logic [YW-1:0]    years_ff;

   always_comb begin
      len      = TW'(cdl_pkg::year_len(kind, cdl_pkg::is_leap(kind, in_ctl.r100, in_ctl.q4)));
      step     = (in_temp > len);
      ctl_in   = in_ctl;
      temp_in  = in_temp;
      years_in = in_years;
      if (step) begin
         temp_in  = in_temp - len;
         years_in = in_years + YW'(1);
         if (in_ctl.r100 == 7'd99) begin
            ctl_in.r100 = 7'd0;
            ctl_in.q4   = in_ctl.q4 + 2'd1;
         end else begin
            ctl_in.r100 = in_ctl.r100 + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.status <= ctl_in.status;
      ctl_ff.r100   <= ctl_in.r100;
      ctl_ff.q4     <= ctl_in.q4;
      temp_ff       <= temp_in;
      years_ff      <= years_in;
   end

   assign out_ctl   = ctl_ff;
   assign out_temp  = temp_ff;
   assign out_years = years_ff;

endmodule

/* sv/cdl_locate.sv */
// ----------------------------------------------------------------------------
// cdl_locate
// Back stages: find the month of the day, then the day in month, the
// trailing day number and the season.
// ----------------------------------------------------------------------------
module cdl_locate #(
   parameter int unsigned TW = 13,
   parameter int unsigned YW = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  cdl_pkg::kind_type kind,
   input  cdl_pkg::ctl_type  in_ctl,
   input  logic [TW-1:0]     in_temp,
   input  logic [YW-1:0]     in_years,
   output logic              out_valid,
   output cdl_pkg::rsp_type  out_rsp
);

   // stage L1: month search
   logic             leap;
   logic [3:0]       mon;
   logic             l1_valid_ff;
   logic [1:0]       l1_status_ff;
   logic [3:0]       l1_years_ff;
   logic [8:0]       l1_day_ff;
   logic [3:0]       l1_mon_ff;
   logic             l1_leap_ff;

   always_comb begin
      leap = cdl_pkg::is_leap(kind, in_ctl.r100, in_ctl.q4);
      mon  = 4'd0;
      for (int i = 1; i < cdl_pkg::NMON; i++) begin
         if (cdl_pkg::month_start(kind, leap, 4'(i)) <= in_temp[8:0]) begin
            mon = 4'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
      end else begin
         l1_valid_ff <= in_ctl.valid;
      end
      l1_status_ff <= in_ctl.status;
      l1_years_ff  <= in_years[3:0];
      l1_day_ff    <= in_temp[8:0];
      l1_mon_ff    <= mon;
      l1_leap_ff   <= leap;
   end

   // stage L2: fields of the located day
   logic [8:0]       start;
   logic [8:0]       mend;
   logic [8:0]       dim;
   logic [8:0]       extra;
   logic [1:0]       season;
   cdl_pkg::rsp_type rsp;
   logic             l2_valid_ff;
   cdl_pkg::rsp_type l2_rsp_ff;

   always_comb begin
      start = cdl_pkg::month_start(kind, l1_leap_ff, l1_mon_ff);
      mend  = start + {3'd0, cdl_pkg::month_len(kind, l1_leap_ff, l1_mon_ff)} - 9'd1;
      dim   = l1_day_ff - start + 9'd1;
      extra = (l1_day_ff > mend) ? (l1_day_ff - mend) : 9'd0;
      if (l1_day_ff < cdl_pkg::season_div(kind, l1_leap_ff, 2'd0)) begin
         season = 2'd0;
      end else if (l1_day_ff < cdl_pkg::season_div(kind, l1_leap_ff, 2'd1)) begin
         season = 2'd1;
      end else if (l1_day_ff < cdl_pkg::season_div(kind, l1_leap_ff, 2'd2)) begin
         season = 2'd2;
      end else if (l1_day_ff < cdl_pkg::season_div(kind, l1_leap_ff, 2'd3)) begin
         season = 2'd3;
      end else begin
         season = 2'd0;
      end
      rsp = '0;
      rsp.status = l1_status_ff;
      if (l1_status_ff == cdl_pkg::ST_OK) begin
         rsp.years_later     = l1_years_ff;
         rsp.month           = l1_mon_ff;
         rsp.day_in_month    = dim[5:0];
         rsp.extra_day       = extra[3:0];
         rsp.season          = season;
         rsp.day_of_year_out = l1_day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l2_valid_ff <= 1'b0;
      end else begin
         l2_valid_ff <= l1_valid_ff;
      end
      l2_rsp_ff <= rsp;
   end

   assign out_valid = l2_valid_ff;
   assign out_rsp   = l2_rsp_ff;

endmodule

/* sv/calendar_date_locator.sv */
// ----------------------------------------------------------------------------
// calendar_date_locator
// Calendar date engine: day of year plus offset to year, month, day, extra
// day and season, and month/day to day of year, for three fixed calendars.
// ----------------------------------------------------------------------------
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_data          in         start & !busy
//  response  rsp_valid, rsp_data            out        one-cycle strobe
//  config    csr_we, csr_index, csr_wdata   in         write on csr_we
//
//  A transaction enters in any cycle and its response leaves after three front
//  stages, one stage per walked year and two locate stages. The year walk sets
//  the depth. busy is high only during reset; synchronous reset empties the
//  pipeline. The receiver cannot stall, so the pipeline never holds.
//
module calendar_date_locator #(
   parameter int unsigned MAX_DAYS_AFTER = cdl_pkg::MAX_DAYS_AFTER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cdl_pkg::req_type req_data,
   output logic             rsp_valid,
   output cdl_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [13:0]      csr_wdata
);

   // count width covers start day plus largest offset
   localparam int unsigned TW   = $clog2(MAX_DAYS_AFTER + 367);
   // shortest year is 364 days; one spare stage for margin
   localparam int unsigned WALK = (MAX_DAYS_AFTER + 366) / 364 + 1;
   localparam int unsigned YW   = (WALK < 16) ? 4 : $clog2(WALK + 1);

   // configuration registers
   logic [1:0]        kind_ff;
   logic [13:0]       year_ff;
   cdl_pkg::kind_type kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 2'd0;
         year_ff <= 14'd2002;
      end else if (csr_we) begin
         unique case (cdl_pkg::csr_idx_type'(csr_index))
            cdl_pkg::CSR_KIND: kind_ff <= csr_wdata[1:0];
            cdl_pkg::CSR_YEAR: year_ff <= csr_wdata;
            default:           kind_ff <= kind_ff;
         endcase
      end
   end

   // spare kind code behaves as Gregorian
   assign kind = (cdl_pkg::kind_type'(kind_ff) == cdl_pkg::KIND_SPARE) ?
                 cdl_pkg::KIND_GREG : cdl_pkg::kind_type'(kind_ff);

   assign busy = reset;

   cdl_pkg::ctl_type ctl   [WALK+1];
   logic [TW-1:0]    temp  [WALK+1];
   logic [YW-1:0]    years [WALK+1];

   cdl_prep #(
      .MAX_DAYS_AFTER (MAX_DAYS_AFTER),
      .TW             (TW)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .kind      (kind),
      .base_year (year_ff),
      .out_ctl   (ctl[0]),
      .out_temp  (temp[0])
   );

   assign years[0] = '0;

   // advance at most one year per stage
   for (genvar g = 0; g < WALK; g++) begin : g_walk
      cdl_walk_stage #(
         .TW (TW),
         .YW (YW)
      ) u_walk (
         .clock     (clock),
         .reset     (reset),
         .kind      (kind),
         .in_ctl    (ctl[g]),
         .in_temp   (temp[g]),
         .in_years  (years[g]),
         .out_ctl   (ctl[g+1]),
         .out_temp  (temp[g+1]),
         .out_years (years[g+1])
      );
   end

   cdl_locate #(
      .TW (TW),
      .YW (YW)
   ) u_locate (
      .clock     (clock),
      .reset     (reset),
      .kind      (kind),
      .in_ctl    (ctl[WALK]),
      .in_temp   (temp[WALK]),
      .in_years  (years[WALK]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a failed transaction carries nothing but its status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != cdl_pkg::ST_OK) |->
         (rsp_data.day_of_year_out == 9'd0) && (rsp_data.month == 4'd0) &&
         (rsp_data.years_later == 4'd0))
      else $error("error response carries data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != cdl_pkg::ST_SPARE))
      else $error("undefined status code");

   // a good day lands inside a real month
   a_ok_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == cdl_pkg::ST_OK) |->
         (rsp_data.day_in_month != 6'd0) && (rsp_data.month <= 4'd11) &&
         (rsp_data.day_of_year_out != 9'd0))
      else $error("located day out of range");
`endif

endmodule

/* sim/tb_calendar_date_locator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_date_locator
// Self-checking bench for the calendar date locator: an in-bench date model
// predicts every response, directed corners then random transactions across
// calendar kinds and sampled base years, with random idle bursts on the request
// side in all but the last phase.
// ----------------------------------------------------------------------------
module tb_calendar_date_locator;

   localparam int unsigned OFFSET_LIMIT = 4095;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   cdl_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   cdl_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = '0;
   logic [13:0]       csr_wdata = '0;

   // bench copy of the configuration registers
   cdl_pkg::kind_type cal_kind;
   logic [13:0]       cal_year;

   cdl_pkg::rsp_type  pending_dates[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_enable = 1'b1;

   calendar_date_locator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Date model
   // ---------------------------------------------------------------------
   typedef struct {
      int first[12];
      int last[12];
      int total;
      int bound[4];
   } year_map_type;

   function automatic bit leap_year(int k, int y);
      if (k == 1) return (y % 4) == 0;
      if (k == 2) return 1'b0;
      return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
   endfunction

   function automatic int body_days(int k, int m);
      int greg[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (k == 1) return 30;
      if (k == 2) return 28;
      return greg[m];
   endfunction

   function automatic int tail_days(int k, int m);
      int thirty[12] = '{1, 0, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0};
      if (k == 1) return thirty[m];
      if (k == 2) return (m % 3 == 2) ? 7 : 0;
      return 0;
   endfunction

   function automatic year_map_type map_year(int k, int y);
      year_map_type ym;
      bit lp;
      int run, c;
      int marks[4];
      int shift[4];
      lp  = leap_year(k, y);
      run = 0;
      for (int i = 0; i < 12; i++) begin
         ym.first[i] = run + 1;
         run += body_days(k, i);
         if (k == 0 && lp && i == 1) run++;
         ym.last[i] = run;
         run += tail_days(k, i);
         if (k == 1 && lp && i == 6) run++;
      end
      ym.total = run;
      // season boundaries: marked month and its change day
      if (k == 2) begin
         marks = '{1, 5, 9, 11};
         shift = '{1, 32, 1, 1};
      end else begin
         marks = '{2, 5, 8, 11};
         if (k == 1) begin
            shift = '{19, 10, 21, 20};
         end else begin
            shift = '{22, 22, 22, 22};
         end
      end
      for (c = 0; c < 4; c++) ym.bound[c] = ym.first[marks[c]] + shift[c] - 1;
      return ym;
   endfunction

   function automatic void place_day(year_map_type ym, int d, ref cdl_pkg::rsp_type r);
      int m = 0;
      for (int i = 0; i < 12; i++) if (ym.first[i] <= d) m = i;
      r.month        = 4'(m);
      r.day_in_month = 6'(d - ym.first[m] + 1);
      r.extra_day    = (d > ym.last[m]) ? 4'(d - ym.last[m]) : 4'd0;
      if (d < ym.bound[0])      r.season = 2'd0;
      else if (d < ym.bound[1]) r.season = 2'd1;
      else if (d < ym.bound[2]) r.season = 2'd2;
      else if (d < ym.bound[3]) r.season = 2'd3;
      else                      r.season = 2'd0;
      r.day_of_year_out = 9'(d);
   endfunction

   function automatic cdl_pkg::rsp_type predict_date(cdl_pkg::req_type q);
      cdl_pkg::rsp_type r = '0;
      int k, y, d, years, limit;
      year_map_type ym;
      k  = (cal_kind == cdl_pkg::KIND_SPARE) ? 0 : int'(cal_kind);
      y  = int'(cal_year);
      ym = map_year(k, y);
      if (q.cmd == cdl_pkg::CMD_LOCATE) begin
         if (q.day_of_year < 1 || q.day_of_year > ym.total ||
             q.days_after > OFFSET_LIMIT) begin
            r.status = cdl_pkg::ST_BAD_DAY;
            return r;
         end
         d = int'(q.day_of_year) + int'(q.days_after);
         years = 0;
         while (d > ym.total) begin
            d -= ym.total;
            years++;
            y++;
            ym = map_year(k, y);
         end
         r.years_later = 4'(years);
         place_day(ym, d, r);
      end else begin
         if (q.month_in >= 12) begin
            r.status = cdl_pkg::ST_BAD_DAY;
            return r;
         end
         limit = body_days(k, q.month_in) + tail_days(k, q.month_in);
         if (leap_year(k, y) && ((k == 0 && q.month_in == 1) || (k == 1 && q.month_in == 6)))
            limit++;
         if (q.day_in_month_in < 1 || q.day_in_month_in > limit) begin
            r.status = cdl_pkg::ST_BAD_DIM;
            return r;
         end
         place_day(ym, ym.first[q.month_in] + int'(q.day_in_month_in) - 1, r);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cdl_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_dates.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected response %p", rsp_data);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_data !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Leave start high after the transaction so the next one can follow at once.
   task automatic send_date(cdl_pkg::req_type q);
      int gap;
      // random idle burst ahead of the transaction
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_dates.push_back(predict_date(q));
   endtask

   // Wait for all responses, then let the pipeline settle.
   task automatic drain_dates();
      start <= 1'b0;
      @(posedge clock);
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(cdl_pkg::csr_idx_type idx, logic [13:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == cdl_pkg::CSR_KIND) cal_kind = cdl_pkg::kind_type'(value[1:0]);
      else                          cal_year = value;
   endtask

   function automatic cdl_pkg::req_type locate_req(int doy, int after);
      cdl_pkg::req_type q = '0;
      q.cmd             = cdl_pkg::CMD_LOCATE;
      q.day_of_year     = 9'(doy);
      q.days_after      = 12'(after);
      q.month_in        = 4'($urandom);
      q.day_in_month_in = 6'($urandom);
      return q;
   endfunction

   function automatic cdl_pkg::req_type doy_req(int m, int d);
      cdl_pkg::req_type q = '0;
      q.cmd             = cdl_pkg::CMD_TO_DOY;
      q.month_in        = 4'(m);
      q.day_in_month_in = 6'(d);
      q.day_of_year     = 9'($urandom);
      q.days_after      = 12'($urandom);
      return q;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // reset settings first: Gregorian, default base year
      send_date(locate_req(0, 0));        // day zero
      send_date(locate_req(511, 0));      // day beyond year
      send_date(locate_req(365, 0));
      send_date(locate_req(1, 4095));     // largest offset
      send_date(locate_req(365, 1));      // year rollover
      send_date(doy_req(12, 1));          // bad month
      send_date(doy_req(15, 63));
      send_date(doy_req(0, 0));           // day in month zero
      send_date(doy_req(1, 29));          // no leap day in this year
      send_date(doy_req(11, 31));
      send_date(doy_req(0, 1));           // early winter
      drain_dates();
      write_csr(cdl_pkg::CSR_YEAR, 14'd2000);   // century leap year
      send_date(doy_req(1, 29));
      send_date(locate_req(366, 4095));
      drain_dates();
      write_csr(cdl_pkg::CSR_KIND, 14'(cdl_pkg::KIND_THIRTY));
      write_csr(cdl_pkg::CSR_YEAR, 14'd2004);
      send_date(doy_req(6, 32));          // leap day after extra day
      send_date(doy_req(6, 33));
      send_date(locate_req(366, 0));
      drain_dates();
      write_csr(cdl_pkg::CSR_KIND, 14'(cdl_pkg::KIND_FEST));
      write_csr(cdl_pkg::CSR_YEAR, 14'd16383);  // year count past register width
      send_date(doy_req(11, 35));         // last festival day
      send_date(locate_req(364, 4095));
      send_date(locate_req(365, 0));
      drain_dates();
      write_csr(cdl_pkg::CSR_KIND, 14'(cdl_pkg::KIND_SPARE));  // spare kind acts as Gregorian
      write_csr(cdl_pkg::CSR_YEAR, 14'd1900);
      send_date(doy_req(1, 29));
      send_date(locate_req(59, 1));
      drain_dates();
   endtask

   task automatic test_random_phase(int count);
      cdl_pkg::req_type q;
      year_map_type ym;
      int sel, total;
      // phase settings: extremes of the year register now and then
      write_csr(cdl_pkg::CSR_KIND, 14'($urandom_range(0, 3)));
      sel = $urandom_range(0, 5);
      write_csr(cdl_pkg::CSR_YEAR, sel == 0 ? 14'd0 : sel == 1 ? 14'd16383 :
                sel == 2 ? 14'($urandom_range(1896, 2104)) : 14'($urandom));
      ym    = map_year((cal_kind == cdl_pkg::KIND_SPARE) ? 0 : int'(cal_kind), int'(cal_year));
      total = ym.total;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 19);
         if (sel < 8)
            q = locate_req($urandom_range(1, total),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, 800));
         else if (sel < 16)
            q = doy_req($urandom_range(0, 11), $urandom_range(1, 36));
         else
            q = cdl_pkg::req_type'($urandom);   // raw noise over every field bit
         if (sel == 19) q.days_after = 12'hFFF;
         send_date(q);
      end
      drain_dates();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      cal_kind = cdl_pkg::KIND_GREG;
      cal_year = 14'd2002;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int p = 0; p < 12; p++) test_random_phase(110);
      idle_enable = 1'b0;         // tail of the run at full rate
      test_random_phase(100);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
